// ----- hdl/windowed_frame_rate_meter_macros.svh -----
// Assertion macros shared by the frame rate meter RTL.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef WINDOWED_FRAME_RATE_METER_MACROS_SVH
`define WINDOWED_FRAME_RATE_METER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define WFRM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("frame rate meter check failed");
// Next-cycle implication, disabled while reset is asserted.
`define WFRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("frame rate meter check failed");
`else
`define WFRM_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define WFRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hdl/wfrm_pkg.sv -----
// Shared types, codes and helpers for the windowed frame rate meter.
// Used by wfrm_ring, wfrm_div and windowed_frame_rate_meter; no dependencies.
package wfrm_pkg;

  localparam int unsigned WFRM_RING_DEPTH = 64;
  localparam int unsigned WFRM_TIME_WIDTH = 32;

  localparam int unsigned AVG_W      = 6;
  localparam int unsigned NUM_W      = 24;
  localparam int unsigned CNT_W      = $clog2(NUM_W);
  localparam int unsigned RATE_SCALE = 1000;
  localparam int unsigned FRAC_BITS  = 8;
  localparam logic [AVG_W-1:0] AVG_RESET = 6'd16;
  localparam logic [NUM_W-1:0] RATE_MAX  = {NUM_W{1'b1}};

  localparam logic [1:0] OP_FRAME   = 2'd0;
  localparam logic [1:0] OP_RATE    = 2'd1;
  localparam logic [1:0] OP_ELAPSED = 2'd2;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_ZERO_TIME   = 2'd1;
  localparam logic [1:0] STAT_ZERO_PERIOD = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [23:0] rate_q8;
    logic [31:0] elapsed_ms;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } ring_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Reduces a period value modulo the ring depth by restoring subtraction.
  function automatic logic [AVG_W-1:0] avg_mod(input logic [AVG_W-1:0] v,
                                               input int unsigned depth);
    logic [31:0] rem;
    logic [31:0] step;
    rem = 32'(v);
    for (int k = AVG_W - 1; k >= 0; k--) begin
      step = 32'(depth) << k;
      if (rem >= step) begin
        rem = rem - step;
      end
    end
    return AVG_W'(rem);
  endfunction

endpackage

// ----- hdl/wfrm_ring.sv -----
// Timestamp ring memory with one shared read/write port and registered read data.
// Depends on wfrm_pkg. Entries never written read as zero, tracked by a fill count.
module wfrm_ring import wfrm_pkg::*; #(
  parameter int unsigned RING_DEPTH = WFRM_RING_DEPTH,
  parameter int unsigned TIME_WIDTH = WFRM_TIME_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ring_cmd_t                     cmd,
  input  logic [$clog2(RING_DEPTH)-1:0] addr,
  input  logic [TIME_WIDTH-1:0]         wdata,
  output logic [TIME_WIDTH-1:0]         rdata
);

  localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);

  logic [TIME_WIDTH-1:0] mem [RING_DEPTH];
  logic [TIME_WIDTH-1:0] rd_data_r;
  logic                  rd_ok_r;
  logic                  rd_ok_nxt;
  logic [FILL_W-1:0]     fill_r;
  logic [FILL_W-1:0]     fill_nxt;
  logic                  full;

  // Frames are written at consecutive addresses starting at one, so an entry
  // has been written once the fill count reaches it, and all of them are
  // written once the count saturates at the depth.
  assign full = (fill_r == FILL_W'(RING_DEPTH));

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.wr && !full) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
    rd_ok_nxt = full || ((addr != '0) && (fill_r >= FILL_W'(addr)));
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (cmd.rd) begin
        rd_ok_r <= rd_ok_nxt;
      end
    end
  end

  assign rdata = rd_ok_r ? rd_data_r : '0;

endmodule

// ----- hdl/wfrm_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on wfrm_pkg for the numerator width and status struct.
module wfrm_div import wfrm_pkg::*; #(
  parameter int unsigned TIME_WIDTH = WFRM_TIME_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [NUM_W-1:0]      num,
  input  logic [TIME_WIDTH-1:0] den,
  output div_stat_t             stat,
  output logic [NUM_W-1:0]      quot
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [NUM_W-1:0]      num_r, num_nxt;
  logic [NUM_W-1:0]      quot_r, quot_nxt;
  logic [TIME_WIDTH-1:0] den_r, den_nxt;
  logic [TIME_WIDTH-1:0] rem_r, rem_nxt;
  logic [TIME_WIDTH:0]   shifted;
  logic [TIME_WIDTH:0]   trial;

  assign shifted = {rem_r, num_r[NUM_W-1]};
  assign trial   = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quot_nxt = quot_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W - 1);
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      quot_nxt = '0;
    end else if (busy_r) begin
      num_nxt = num_r << 1;
      if (!trial[TIME_WIDTH]) begin
        rem_nxt  = trial[TIME_WIDTH-1:0];
        quot_nxt = {quot_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted[TIME_WIDTH-1:0];
        quot_nxt = {quot_r[NUM_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quot_r;

endmodule

// ----- hdl/windowed_frame_rate_meter.sv -----
// Windowed frame rate meter: top level with the sequencer, pointers and output register.
// Depends on wfrm_pkg, wfrm_ring, wfrm_div and windowed_frame_rate_meter_macros.svh.
//
// Usage: the input channel carries an op code and a millisecond time stamp. A
// frame op stores the time in the next ring slot; a rate op returns, in
// unsigned Q16.8 frames per second, the averaging period times 1000 divided by
// the time between the newest stamp and the stamp that many frames back, and
// remembers the newest stamp as the query time; an elapsed op returns the time
// since that query. The single configuration register holds the period.
// The block works on one transfer at a time. A frame, elapsed or unused op goes
// from the idle state through the execute state to the result state, which loads
// the output register; a rate op reads the newest and the older stamp from the
// ring and runs the 24-step bit-serial divider, and a zero period or zero time
// skips the divider. The output register decouples the two sides, so a new
// transfer is accepted while an earlier result still waits; a finished result
// then waits until the output register frees up. A stalled receiver thus holds
// the block after at most one further transfer. Reset clears the pointers, the
// query time and the fill count of the ring, so unwritten slots read as zero.
`include "windowed_frame_rate_meter_macros.svh"

module windowed_frame_rate_meter import wfrm_pkg::*; #(
  parameter int unsigned RING_DEPTH = WFRM_RING_DEPTH,
  parameter int unsigned TIME_WIDTH = WFRM_TIME_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [AVG_W-1:0] cfg_wdata
);

  localparam int unsigned PTR_W  = $clog2(RING_DEPTH);
  localparam int unsigned DIFF_W = ((PTR_W > AVG_W) ? PTR_W : AVG_W) + 1;

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_EXEC    = 6'b000010,
    S_RD_NEW  = 6'b000100,
    S_RD_BACK = 6'b001000,
    S_DIVIDE  = 6'b010000,
    S_RESULT  = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [TIME_WIDTH-1:0] now_r, now_nxt;
  logic [TIME_WIDTH-1:0] newest_r, newest_nxt;
  logic [TIME_WIDTH-1:0] last_r, last_nxt;
  logic [PTR_W-1:0]      wp_r, wp_nxt;
  logic [AVG_W-1:0]      avg_r, avg_nxt;
  out_t                  res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;

  logic [PTR_W-1:0]      wp_inc;
  logic [DIFF_W-1:0]     back_diff;
  logic [PTR_W-1:0]      back_ptr;
  logic [TIME_WIDTH-1:0] delta;
  logic [TIME_WIDTH-1:0] elapsed_full;

  ring_cmd_t             ring_cmd;
  logic [PTR_W-1:0]      ring_addr;
  logic [TIME_WIDTH-1:0] ring_rdata;

  logic                  div_start;
  logic [NUM_W-1:0]      div_num;
  div_stat_t             div_stat;
  logic [NUM_W-1:0]      div_quot;

  wfrm_ring #(
    .RING_DEPTH (RING_DEPTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ring_cmd),
    .addr  (ring_addr),
    .wdata (now_r),
    .rdata (ring_rdata)
  );

  wfrm_div #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (delta),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // The write pointer always names the newest stamp; a frame advances it first.
  assign wp_inc = (wp_r == PTR_W'(RING_DEPTH - 1)) ? '0 : (wp_r + PTR_W'(1));

  // The period is always below the depth, so one wrap correction suffices.
  assign back_diff = DIFF_W'(wp_r) - DIFF_W'(avg_r);
  assign back_ptr  = back_diff[DIFF_W-1] ? PTR_W'(back_diff + DIFF_W'(RING_DEPTH))
                                         : PTR_W'(back_diff);

  // In the cycle after the second read, the ring output holds the older stamp.
  assign delta        = newest_r - ring_rdata;
  assign elapsed_full = now_r - last_r;

  // Numerator: period times 1000, scaled by 256 for the Q16.8 result.
  assign div_num = NUM_W'(NUM_W'(avg_r) * NUM_W'(RATE_SCALE)) << FRAC_BITS;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    now_nxt       = now_r;
    newest_nxt    = newest_r;
    last_nxt      = last_r;
    wp_nxt        = wp_r;
    avg_nxt       = avg_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ring_cmd      = '0;
    ring_addr     = wp_r;
    div_start     = 1'b0;

    if (cfg_we) begin
      avg_nxt = avg_mod(cfg_wdata, RING_DEPTH);
    end

    // The receiver takes the held result; a new one may be loaded below.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.op;
          now_nxt   = TIME_WIDTH'(in_data.now_ms);
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt = '0;
        unique case (op_r)
          OP_FRAME: begin
            wp_nxt       = wp_inc;
            ring_cmd.wr  = 1'b1;
            ring_addr    = wp_inc;
            state_nxt    = S_RESULT;
          end
          OP_RATE: begin
            ring_cmd.rd  = 1'b1;
            ring_addr    = wp_r;
            state_nxt    = S_RD_NEW;
          end
          OP_ELAPSED: begin
            res_nxt.elapsed_ms = 32'(elapsed_full);
            state_nxt          = S_RESULT;
          end
          default: begin
            // The unused op code leaves the state alone and answers with zeros.
            state_nxt = S_RESULT;
          end
        endcase
      end
      S_RD_NEW: begin
        newest_nxt  = ring_rdata;
        ring_cmd.rd = 1'b1;
        ring_addr   = back_ptr;
        state_nxt   = S_RD_BACK;
      end
      S_RD_BACK: begin
        last_nxt = newest_r;
        if (avg_r == '0) begin
          res_nxt.status = STAT_ZERO_PERIOD;
          state_nxt      = S_RESULT;
        end else if (delta == '0) begin
          res_nxt.rate_q8 = RATE_MAX;
          res_nxt.status  = STAT_ZERO_TIME;
          state_nxt       = S_RESULT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        // The quotient never exceeds the 24-bit numerator, so no clamp is needed.
        if (div_stat.done) begin
          res_nxt.rate_q8 = div_quot;
          state_nxt       = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_FRAME;
      last_r      <= '0;
      wp_r        <= '0;
      avg_r       <= avg_mod(AVG_RESET, RING_DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      last_r      <= last_nxt;
      wp_r        <= wp_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    newest_r   <= newest_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The divider runs only while the sequencer waits for it.
  `WFRM_ASSERT_NOW(a_div_owned, clk, rst_n, div_stat.busy, state_r == S_DIVIDE)
  // A zero period answer always carries a zero rate.
  `WFRM_ASSERT_NOW(a_zero_period_rate, clk, rst_n, out_valid_r && (out_data_r.status == STAT_ZERO_PERIOD), out_data_r.rate_q8 == '0)
  // An elapsed answer never carries rate fields.
  `WFRM_ASSERT_NOW(a_elapsed_clean, clk, rst_n, out_valid_r && (out_data_r.elapsed_ms != '0), (out_data_r.rate_q8 == '0) && (out_data_r.status == STAT_OK))
  // The write pointer stays inside the ring.
  `WFRM_ASSERT_NOW(a_wp_range, clk, rst_n, 1'b1, wp_r <= PTR_W'(RING_DEPTH - 1))
  // A started divide always hands its result over before the next transfer.
  `WFRM_ASSERT_NEXT(a_div_to_result, clk, rst_n, (state_r == S_DIVIDE) && div_stat.done, state_r == S_RESULT)

endmodule

// ----- tb/windowed_frame_rate_meter_tb.sv -----
// Self-checking testbench for the windowed frame rate meter.
// Needs wfrm_pkg and windowed_frame_rate_meter; a scoreboard class predicts every reading.
`timescale 1ns / 1ps

module windowed_frame_rate_meter_tb;
  import wfrm_pkg::*;

  // The package names only the three live op codes; the fourth code is accepted
  // by the block and must come back as an all-zero reading.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Scoreboard: keeps its own copy of the timestamp ring, the write pointer,
  // the last query time and the averaging period, and queues one expected
  // reading per accepted transfer.
  class frame_rate_scoreboard;
    logic [31:0] stamps [WFRM_RING_DEPTH];
    logic [AVG_W-1:0] head;
    logic [31:0] last_query;
    logic [AVG_W-1:0] period;
    out_t pending_readings [$];
    int mismatches;

    function new();
      foreach (stamps[k]) stamps[k] = '0;
      head = '0;
      last_query = '0;
      period = AVG_RESET;
      mismatches = 0;
    endfunction

    // The ring is 64 deep and the register 6 bits wide, so the modulo on the
    // written value is the identity.
    function void set_period(logic [AVG_W-1:0] value);
      period = value;
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction

    function void log_request(in_t item);
      logic [AVG_W-1:0] back;
      logic [31:0] span;
      logic [31:0] quotient;
      out_t reading;
      reading = '0;
      case (item.op)
        OP_FRAME: begin
          head = head + 1'b1;
          stamps[head] = item.now_ms;
        end
        OP_RATE: begin
          // Pointer arithmetic wraps at the ring depth on its own.
          back = head - period;
          span = stamps[head] - stamps[back];
          if (period == '0) begin
            reading.status = STAT_ZERO_PERIOD;
          end else if (span == '0) begin
            reading.rate_q8 = RATE_MAX;
            reading.status = STAT_ZERO_TIME;
          end else begin
            quotient = ((32'(period) * RATE_SCALE) << FRAC_BITS) / span;
            reading.rate_q8 = (quotient > 32'(RATE_MAX)) ? RATE_MAX : quotient[NUM_W-1:0];
          end
          last_query = stamps[head];
        end
        OP_ELAPSED: begin
          reading.elapsed_ms = item.now_ms - last_query;
        end
        default: begin
          // The unused code leaves the state alone.
        end
      endcase
      pending_readings.push_back(reading);
    endfunction

    function void check_reading(out_t got);
      out_t want;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected reading: rate %h elapsed %h status %0d",
                   got.rate_q8, got.elapsed_ms, got.status);
        end
        return;
      end
      want = pending_readings.pop_front();
      if (got.rate_q8 !== want.rate_q8 || got.elapsed_ms !== want.elapsed_ms ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("reading mismatch: expected rate %h elapsed %h status %0d, got rate %h elapsed %h status %0d",
                   want.rate_q8, want.elapsed_ms, want.status,
                   got.rate_q8, got.elapsed_ms, got.status);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we;
  logic [AVG_W-1:0] cfg_wdata;

  // When set, neither side idles: no sender gaps and no receiver stalls.
  logic calm;
  // Millisecond clock that the random frame stamps follow; it advances with the random frames.
  logic [31:0] clock_ms;
  int stall_hold;

  frame_rate_scoreboard rate_board = new();

  windowed_frame_rate_meter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // All inputs are known from time zero, and reset starts asserted.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    calm = 1'b0;
    clock_ms = '0;
    stall_hold = 0;
  end

  // Monitor. Everything is sampled at the rising edge, before the block's
  // registers and our own nonblocking drives have moved, so a transfer is
  // seen exactly when the block takes it. A reading can never come from a
  // transfer taken at the same edge, so checking first is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        rate_board.check_reading(out_data);
      end
      if (in_valid && !in_stall) begin
        rate_board.log_request(in_data);
      end
      if (cfg_we) begin
        rate_board.set_period(cfg_wdata);
      end
    end
  end

  // Receiver back-pressure: stall bursts of random length separated by free
  // runs of random length. The free runs give stretches with no stalls.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold = stall_hold - 1;
    end else if (!out_stall && $urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_hold = $urandom_range(1, 17) - 1;
    end else begin
      out_stall <= 1'b0;
      stall_hold = $urandom_range(0, 60);
    end
  end

  // Offers one transfer and waits for it to be taken. Valid stays high into
  // the next transfer unless a sender gap follows, so it is never lowered and
  // raised in the same step.
  task automatic push_item(input in_t item);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Brings the block to idle: no transfer offered and every reading back.
  // Each transfer yields a reading, so a short pause after that is enough.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rate_board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_period(input logic [AVG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed traffic: frames whose stamps follow a clock that
  // advances by display-like steps (sometimes not at all, to get equal stamps),
  // rate queries, and elapsed queries a little after the clock. The rest is
  // noise: the unused code and transfers carrying arbitrary times.
  function automatic in_t random_request();
    int pick;
    in_t item;
    pick = $urandom_range(0, 99);
    item.op = OP_FRAME;
    item.now_ms = $urandom();
    if (pick < 50) begin
      clock_ms = clock_ms + (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 40));
      item.now_ms = clock_ms;
    end else if (pick < 70) begin
      item.op = OP_RATE;
    end else if (pick < 85) begin
      item.op = OP_ELAPSED;
      item.now_ms = clock_ms + $urandom_range(0, 100);
    end else if (pick < 91) begin
      item.op = OP_UNUSED;
    end else if (pick >= 96) begin
      item.op = OP_ELAPSED;
    end
    return item;
  endfunction

  initial begin
    int plan [9] = '{63, 1, 0, 2, 40, -1, 62, -1, 16};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first with the reset period of 16. A rate query on the
    // cleared ring sees zero elapsed time and saturates.
    push_item({OP_RATE, 32'hFFFF_FFFF});
    push_item({OP_ELAPSED, 32'hFFFF_FFFF});
    push_item({OP_UNUSED, 32'hFFFF_FFFF});
    push_item({OP_UNUSED, 32'h0000_0000});
    push_item({OP_FRAME, 32'hFFFF_FFFF});
    push_item({OP_FRAME, 32'h0000_0003});
    // The stamp sixteen back is a cleared slot, behind the pointer wrap.
    push_item({OP_RATE, 32'h0000_0000});
    // Elapsed time that wraps below the last query time, then exactly zero.
    push_item({OP_ELAPSED, 32'h0000_0002});
    push_item({OP_ELAPSED, 32'h0000_0003});
    // A huge window makes the quotient truncate to zero.
    push_item({OP_FRAME, 32'h8000_0000});
    push_item({OP_RATE, 32'h5555_5555});
    push_item({OP_ELAPSED, 32'h7FFF_FFFF});

    // Period of one: equal neighbor stamps saturate, a one-millisecond step
    // gives the largest rate for this period.
    settle();
    write_period(6'd1);
    push_item({OP_FRAME, 32'h8000_0000});
    push_item({OP_RATE, 32'hAAAA_AAAA});
    push_item({OP_FRAME, 32'h8000_0001});
    push_item({OP_RATE, 32'h0000_0000});

    // Zero period reports a zero rate but still moves the query time.
    settle();
    write_period(6'd0);
    push_item({OP_RATE, 32'h0000_0000});
    push_item({OP_FRAME, 32'h1234_5678});
    push_item({OP_RATE, 32'hFFFF_FFFF});
    push_item({OP_ELAPSED, 32'h1234_5678});

    // Longest window: the stamp 63 back sits just past the write pointer.
    settle();
    write_period(6'd63);
    push_item({OP_RATE, 32'h0000_0000});

    // Random phases, each with its own period and time base; one base sits
    // just below the 32-bit wrap. The last phase runs with no idling at all.
    for (int ph = 0; ph < 9; ph++) begin
      settle();
      if (ph == 8) begin
        calm <= 1'b1;
      end
      write_period((plan[ph] < 0) ? AVG_W'($urandom_range(1, 62)) : AVG_W'(plan[ph]));
      clock_ms = (ph == 3) ? 32'hFFFF_FC00 : $urandom();
      repeat (150) push_item(random_request());
    end

    // Wind down: wait for every reading, then a margin for stray ones.
    in_valid <= 1'b0;
    for (int w = 0; w < 20000 && rate_board.pending() != 0; w++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (rate_board.mismatches == 0 && rate_board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
